@@ src/mrf_pkg.sv @@
// ----------------------------------------------------------------------------
// mrf_pkg: shared types and constants for the modbus rtu request framer
// event codes, register indexes, function code lengths and interface structs
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam int DEFAULT_MAX_FRAME = 256;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int CAPACITY_W  = 9;
    localparam int S_DATA_W    = 24;
    localparam int S_USER_W    = 3;
    localparam int M_DATA_W    = 32;

    localparam logic [8:0] CAPACITY_RESET = 9'd256;

    // function code with a byte-count field, all others are fixed length
    localparam logic [7:0] FC_WRITE_MULTIPLE = 8'h10;
    localparam int FIXED_REQ_LEN  = 8;
    localparam int MULTI_REQ_BASE = 9;
    localparam int FC_BYTE_POS    = 1;
    localparam int BYTE_COUNT_CNT = 7;

    typedef enum logic [S_USER_W-1:0] {
        ACT_RX_BYTE     = 3'd0,
        ACT_TAKE_FRAME  = 3'd1,
        ACT_TX_START    = 3'd2,
        ACT_TX_COMPLETE = 3'd3,
        ACT_LINE_ERROR  = 3'd4,
        ACT_REINIT      = 3'd5
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PORT_OPEN         = 1'd0,
        CFG_CONSUMER_CAPACITY = 1'd1
    } cfg_index_t;

    typedef struct packed {
        logic                  port_open;
        logic [CAPACITY_W-1:0] consumer_capacity;
    } cfg_t;

    typedef struct packed {
        logic       fault;
        logic       drive_enable;
        logic       tx_busy;
        logic [8:0] taken_length;
        logic       frame_waiting;
        logic       frame_complete;
        logic [7:0] byte_index;
        logic [7:0] byte_out;
        logic       accepted;
    } result_t;

endpackage

@@ src/mrf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mrf_cfg_regs: configuration registers
// holds port open and consumer capacity, written through a plain write port
// ----------------------------------------------------------------------------
module mrf_cfg_regs
    import mrf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    logic                  port_open_reg;
    logic [CAPACITY_W-1:0] capacity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_open_reg <= 1'b0;
            capacity_reg  <= CAPACITY_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_PORT_OPEN: begin
                    port_open_reg <= cfg_wdata[0];
                end
                CFG_CONSUMER_CAPACITY: begin
                    capacity_reg <= cfg_wdata[CAPACITY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.port_open         = port_open_reg;
    assign cfg.consumer_capacity = capacity_reg;

endmodule

@@ src/mrf_core.sv @@
// ----------------------------------------------------------------------------
// mrf_core: framer state and per-event update
// counts request bytes, derives the expected length, tracks transmit state
// ----------------------------------------------------------------------------
module mrf_core
    import mrf_pkg::*;
#(
    parameter int MAX_FRAME = DEFAULT_MAX_FRAME
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                in_fire,
    input  logic [S_USER_W-1:0] action,
    input  logic [7:0]          rx_byte,
    input  logic [15:0]         tx_length,
    output result_t             result
);

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [CW-1:0] rx_count_reg, rx_count_next;
    logic [CW-1:0] expected_reg, expected_next;
    logic [7:0]    func_code_reg, func_code_next;
    logic          ready_reg, ready_next;
    logic          error_reg, error_next;
    logic          busy_reg, busy_next;
    logic          dir_reg, dir_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_count_reg  <= '0;
            expected_reg  <= '0;
            func_code_reg <= '0;
            ready_reg     <= 1'b0;
            error_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            dir_reg       <= 1'b0;
        end else if (in_fire) begin
            rx_count_reg  <= rx_count_next;
            expected_reg  <= expected_next;
            func_code_reg <= func_code_next;
            ready_reg     <= ready_next;
            error_reg     <= error_next;
            busy_reg      <= busy_next;
            dir_reg       <= dir_next;
        end
    end

    always_comb begin
        logic [CW-1:0] cnt_inc;
        logic [CW-1:0] exp_len;
        logic [7:0]    fc;
        logic [9:0]    multi_len;
        logic [15:0]   idx_ext;
        logic          bad;

        rx_count_next  = rx_count_reg;
        expected_next  = expected_reg;
        func_code_next = func_code_reg;
        ready_next     = ready_reg;
        error_next     = error_reg;
        busy_next      = busy_reg;
        dir_next       = dir_reg;

        result.accepted       = 1'b0;
        result.byte_out       = 8'd0;
        result.byte_index     = 8'd0;
        result.frame_complete = 1'b0;
        result.taken_length   = 9'd0;

        cnt_inc   = rx_count_reg + CW'(1);
        fc        = (rx_count_reg == CW'(FC_BYTE_POS)) ? rx_byte : func_code_reg;
        multi_len = {2'b00, rx_byte} + 10'(MULTI_REQ_BASE);
        idx_ext   = 16'(rx_count_reg);
        exp_len   = expected_reg;
        bad       = 1'b0;

        case (action_t'(action))
            ACT_RX_BYTE: begin
                if (cfg.port_open && !ready_reg) begin
                    if (rx_count_reg < CW'(MAX_FRAME)) begin
                        func_code_next = fc;
                        if (cnt_inc >= CW'(2)) begin
                            if (fc != FC_WRITE_MULTIPLE) begin
                                exp_len = CW'(FIXED_REQ_LEN);
                            end else if (cnt_inc == CW'(BYTE_COUNT_CNT)) begin
                                if (multi_len <= 10'(MAX_FRAME)) begin
                                    exp_len = multi_len[CW-1:0];
                                end else begin
                                    bad = 1'b1;
                                end
                            end
                        end
                        if (bad) begin
                            error_next    = 1'b1;
                            rx_count_next = '0;
                            expected_next = '0;
                            ready_next    = 1'b0;
                        end else begin
                            rx_count_next     = cnt_inc;
                            expected_next     = exp_len;
                            result.accepted   = 1'b1;
                            result.byte_out   = rx_byte;
                            result.byte_index = idx_ext[7:0];
                            if (exp_len != '0 && cnt_inc >= exp_len) begin
                                ready_next            = 1'b1;
                                result.frame_complete = 1'b1;
                            end
                        end
                    end else begin
                        error_next    = 1'b1;
                        rx_count_next = '0;
                        expected_next = '0;
                        ready_next    = 1'b0;
                    end
                end
            end
            ACT_TAKE_FRAME: begin
                if (ready_reg) begin
                    if (rx_count_reg != '0 &&
                        9'(rx_count_reg) <= cfg.consumer_capacity) begin
                        result.accepted     = 1'b1;
                        result.taken_length = 9'(rx_count_reg);
                    end
                    rx_count_next = '0;
                    expected_next = '0;
                    ready_next    = 1'b0;
                end
            end
            ACT_TX_START: begin
                if (tx_length != 16'd0 && tx_length <= 16'(MAX_FRAME) &&
                    cfg.port_open && !busy_reg) begin
                    dir_next        = 1'b1;
                    busy_next       = 1'b1;
                    result.accepted = 1'b1;
                end
            end
            ACT_TX_COMPLETE: begin
                if (cfg.port_open) begin
                    dir_next  = 1'b0;
                    busy_next = 1'b0;
                end
            end
            ACT_LINE_ERROR: begin
                if (cfg.port_open) begin
                    error_next    = 1'b1;
                    rx_count_next = '0;
                    expected_next = '0;
                    ready_next    = 1'b0;
                    busy_next     = 1'b0;
                    dir_next      = 1'b0;
                end
            end
            ACT_REINIT: begin
                rx_count_next  = '0;
                expected_next  = '0;
                func_code_next = '0;
                ready_next     = 1'b0;
                error_next     = 1'b0;
                busy_next      = 1'b0;
                dir_next       = 1'b0;
            end
            default: begin
            end
        endcase

        result.frame_waiting = ready_next;
        result.tx_busy       = busy_next;
        result.drive_enable  = dir_next;
        result.fault         = !cfg.port_open || error_next;
    end

endmodule

@@ src/mrf_out_stage.sv @@
// ----------------------------------------------------------------------------
// mrf_out_stage: result register
// holds one result for the master side and backpressures the slave side
// ----------------------------------------------------------------------------
module mrf_out_stage
    import mrf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  result_t             result,
    output logic                in_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic    valid_reg;
    result_t data_reg;

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_fire) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_DATA_W'(data_reg);

endmodule

@@ src/modbus_rtu_request_framer.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer: modbus rtu request length framer
// one request per event: rx byte, take frame, tx start, tx complete,
// line error or reinitialize; each request gives exactly one result.
// s_tuser carries the event code, s_tdata the byte and the tx length.
// each accepted byte comes back with its index so the consumer can store
// the frame; the result also reports frame completion, the frozen frame,
// the taken length, transmit busy, rs485 drive enable and fault.
// latency: the result is valid the cycle after the request is taken.
// throughput: one request per cycle while m_tready is high, set by the single result register;
// a new request is taken in the same cycle the held result is taken.
// when m_tready is low the result is held and s_tready drops until it
// is taken. reset clears all framer state, closes the port and sets the
// consumer capacity to 256; the config port writes the two registers.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer
    import mrf_pkg::*;
#(
    parameter int MAX_FRAME = DEFAULT_MAX_FRAME
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // rx_byte[7:0], tx_length[23:8]
    input  logic [S_DATA_W-1:0]    s_tdata,
    // action[2:0]
    input  logic [S_USER_W-1:0]    s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // accepted[0], byte_out[8:1], byte_index[16:9], frame_complete[17],
    // frame_waiting[18], taken_length[27:19], tx_busy[28], drive_enable[29],
    // fault[30], zero[31]
    output logic [M_DATA_W-1:0]    m_tdata
);

    cfg_t    cfg;
    result_t result;
    logic    in_fire;

    assign in_fire = s_tvalid && s_tready;

    mrf_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mrf_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_fire   (in_fire),
        .action    (s_tuser),
        .rx_byte   (s_tdata[7:0]),
        .tx_length (s_tdata[23:8]),
        .result    (result)
    );

    mrf_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .result   (result),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_stall_only_when_held: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready)
    ) else $error("input stalled while result register free");

    a_request_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_tvalid
    ) else $error("taken request produced no result");

    a_drive_tracks_busy: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29] == m_tdata[28])
    ) else $error("drive enable differs from tx busy");

    a_complete_freezes: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[17]) |-> (m_tdata[18] && m_tdata[0])
    ) else $error("completed frame not frozen or not accepted");

endmodule
